@@ hdl/rgb2hsv_pkg.sv @@
// Shared widths and fixed-point constants for the RGB to HSV pixel converter.
package rgb2hsv_pkg;

    localparam int CH_W           = 8;   // one color channel sample
    localparam int HUE_W          = 15;  // hue result field
    localparam int HUE_FRAC_DEF   = 6;   // default fraction bits of hue
    localparam int HUE_FRAC_MAX   = 10;
    localparam int HUE_INT_W      = 9;   // integer degrees 0..359
    localparam int NUM_W          = 17;  // hue numerator, below 360*255
    localparam int DIFF_W         = CH_W + 1;
    localparam int SAT_DIV_W      = 2 * CH_W;
    localparam int SAT_Q_W        = CH_W;

    localparam int HUE_SCALE      = 60;
    localparam int HUE_OFF_GREEN  = 120;
    localparam int HUE_OFF_BLUE   = 240;
    localparam int HUE_WRAP       = 360;
    localparam int SAT_SCALE      = 255;

endpackage

@@ hdl/rgb_to_hsv_pixel_top.sv @@
// RGB to HSV pixel converter: front end plus pipelined restoring dividers.
//
// Converts one 8-bit RGB pixel per transaction into hue (1/2^HUE_FRAC_BITS
// degree units, truncated toward zero, wrapped into [0, 360) degrees),
// saturation (floor(delta*255/max), 0 for black), brightness (max channel)
// and a pass-through end-of-frame flag. The block is fully pipelined and
// accepts one pixel every cycle unless m_ready stalls it. It has three
// front-end stages (input register, max/min and branch select, numerator
// build) followed by one stage per hue quotient bit, 9 + HUE_FRAC_BITS of
// them; the saturation quotient is resolved in the last 8 of those stages.
// Backpressure on m_ready freezes the whole pipe; s_ready is high whenever
// the output stage is empty or being taken.
module rgb_to_hsv_pixel_top #(
    parameter int HUE_FRAC_BITS = rgb2hsv_pkg::HUE_FRAC_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rgb2hsv_pkg::CH_W-1:0] s_red,
    input  logic [rgb2hsv_pkg::CH_W-1:0] s_green,
    input  logic [rgb2hsv_pkg::CH_W-1:0] s_blue,
    input  logic                         s_end_of_frame,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rgb2hsv_pkg::HUE_W-1:0] m_hue,
    output logic [rgb2hsv_pkg::CH_W-1:0]  m_saturation,
    output logic [rgb2hsv_pkg::CH_W-1:0]  m_brightness,
    output logic                          m_frame_end
);
    import rgb2hsv_pkg::*;

    // quotient bits of the hue divider and width of its dividend
    localparam int QH     = HUE_INT_W + HUE_FRAC_BITS;
    localparam int HDIV_W = NUM_W + HUE_FRAC_BITS;
    localparam int EXT_W  = (QH > HUE_W) ? QH : HUE_W;

    // hue offset added to the scaled channel difference
    typedef enum logic [1:0] {
        OFF_ZERO,
        OFF_GREEN,
        OFF_BLUE,
        OFF_WRAP
    } hue_off_t;

    // whole pipe moves together; output slot free or being drained
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // ---------------- stage 1: input register ----------------
    logic            v1_reg;
    logic [CH_W-1:0] r1_reg, g1_reg, b1_reg;
    logic            eof1_reg;

    // ---------------- stage 2: max/min, delta, branch ----------------
    logic                     v2_reg, v2_next;
    logic [CH_W-1:0]          mx2_reg, mx2_next;
    logic [CH_W-1:0]          dl2_reg, dl2_next;
    logic signed [DIFF_W-1:0] df2_reg, df2_next;
    hue_off_t                 off2_reg, off2_next;
    logic                     eof2_reg;

    // ---------------- stage 3: numerator and dividends ----------------
    logic [NUM_W-1:0]     num3_next;
    logic [SAT_DIV_W-1:0] sdv3_next;

    // divider pipe, index 0 is the front-end output, 1..QH one bit each
    logic                 v_reg     [0:QH];
    logic [HDIV_W-1:0]    rem_h_reg [0:QH];
    logic [QH-1:0]        q_h_reg   [0:QH];
    logic [SAT_DIV_W-1:0] rem_s_reg [0:QH];
    logic [SAT_Q_W-1:0]   q_s_reg   [0:QH];
    logic [CH_W-1:0]      dl_reg    [0:QH];
    logic [CH_W-1:0]      mx_reg    [0:QH];
    logic                 eof_reg   [0:QH];

    logic [HDIV_W-1:0]    rem_h_next [1:QH];
    logic [QH-1:0]        q_h_next   [1:QH];
    logic [SAT_DIV_W-1:0] rem_s_next [1:QH];
    logic [SAT_Q_W-1:0]   q_s_next   [1:QH];

    // stage 2 logic: red wins ties, then green
    always_comb begin
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        mx = r1_reg;
        mn = r1_reg;
        if (g1_reg > mx) mx = g1_reg;
        if (b1_reg > mx) mx = b1_reg;
        if (g1_reg < mn) mn = g1_reg;
        if (b1_reg < mn) mn = b1_reg;
        mx2_next = mx;
        dl2_next = mx - mn;
        v2_next  = v1_reg;
        if (mx == r1_reg) begin
            df2_next  = $signed({1'b0, g1_reg}) - $signed({1'b0, b1_reg});
            // negative red hue wraps by a full turn
            off2_next = df2_next[DIFF_W-1] ? OFF_WRAP : OFF_ZERO;
        end else if (mx == g1_reg) begin
            df2_next  = $signed({1'b0, b1_reg}) - $signed({1'b0, r1_reg});
            off2_next = OFF_GREEN;
        end else begin
            df2_next  = $signed({1'b0, r1_reg}) - $signed({1'b0, g1_reg});
            off2_next = OFF_BLUE;
        end
    end

    // stage 3 logic: num = 60*diff + offset*delta, always non-negative
    always_comb begin
        logic [HUE_INT_W-1:0]    off_mul;
        logic signed [NUM_W:0]   term_a;
        logic [NUM_W-1:0]        term_b;
        logic signed [NUM_W:0]   sum;
        case (off2_reg)
            OFF_ZERO:  off_mul = '0;
            OFF_GREEN: off_mul = HUE_INT_W'(HUE_OFF_GREEN);
            OFF_BLUE:  off_mul = HUE_INT_W'(HUE_OFF_BLUE);
            OFF_WRAP:  off_mul = HUE_INT_W'(HUE_WRAP);
            default:   off_mul = '0;
        endcase
        term_a    = (NUM_W+1)'(df2_reg) * (NUM_W+1)'(signed'(HUE_SCALE));
        term_b    = NUM_W'({{(NUM_W-HUE_INT_W){1'b0}}, off_mul} *
                           {{(NUM_W-CH_W){1'b0}}, dl2_reg});
        sum       = term_a + $signed({1'b0, term_b});
        num3_next = sum[NUM_W-1:0];
        sdv3_next = SAT_DIV_W'({{CH_W{1'b0}}, dl2_reg} * SAT_DIV_W'(SAT_SCALE));
    end

    // one restoring step per stage; saturation uses the last SAT_Q_W stages
    always_comb begin
        int                   hbit;
        logic [HDIV_W-1:0]    hdiv;
        logic [SAT_DIV_W-1:0] sdiv;
        for (int k = 1; k <= QH; k++) begin
            hbit = QH - k;
            hdiv = HDIV_W'(dl_reg[k-1]) << hbit;
            sdiv = SAT_DIV_W'(mx_reg[k-1]) << hbit;
            if (rem_h_reg[k-1] >= hdiv) begin
                rem_h_next[k] = rem_h_reg[k-1] - hdiv;
                q_h_next[k]   = {q_h_reg[k-1][QH-2:0], 1'b1};
            end else begin
                rem_h_next[k] = rem_h_reg[k-1];
                q_h_next[k]   = {q_h_reg[k-1][QH-2:0], 1'b0};
            end
            rem_s_next[k] = rem_s_reg[k-1];
            q_s_next[k]   = q_s_reg[k-1];
            if (hbit < SAT_Q_W) begin
                if (rem_s_reg[k-1] >= sdiv) begin
                    rem_s_next[k] = rem_s_reg[k-1] - sdiv;
                    q_s_next[k]   = {q_s_reg[k-1][SAT_Q_W-2:0], 1'b1};
                end else begin
                    q_s_next[k]   = {q_s_reg[k-1][SAT_Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // valid bits: reset clears them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= QH; k++) v_reg[k] <= 1'b0;
        end else if (adv) begin
            v1_reg   <= s_valid;
            v2_reg   <= v2_next;
            v_reg[0] <= v2_reg;
            for (int k = 1; k <= QH; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg   <= s_red;
            g1_reg   <= s_green;
            b1_reg   <= s_blue;
            eof1_reg <= s_end_of_frame;

            mx2_reg  <= mx2_next;
            dl2_reg  <= dl2_next;
            df2_reg  <= df2_next;
            off2_reg <= off2_next;
            eof2_reg <= eof1_reg;

            rem_h_reg[0] <= HDIV_W'(num3_next) << HUE_FRAC_BITS;
            q_h_reg[0]   <= '0;
            rem_s_reg[0] <= sdv3_next;
            q_s_reg[0]   <= '0;
            dl_reg[0]    <= dl2_reg;
            mx_reg[0]    <= mx2_reg;
            eof_reg[0]   <= eof2_reg;

            for (int k = 1; k <= QH; k++) begin
                rem_h_reg[k] <= rem_h_next[k];
                q_h_reg[k]   <= q_h_next[k];
                rem_s_reg[k] <= rem_s_next[k];
                q_s_reg[k]   <= q_s_next[k];
                dl_reg[k]    <= dl_reg[k-1];
                mx_reg[k]    <= mx_reg[k-1];
                eof_reg[k]   <= eof_reg[k-1];
            end
        end
    end

    // grey pixel gives hue 0, black pixel gives saturation 0
    logic [EXT_W-1:0] hue_ext;
    assign hue_ext = EXT_W'(q_h_reg[QH]);

    assign m_valid      = v_reg[QH];
    assign m_hue        = (dl_reg[QH] == '0) ? '0 : hue_ext[HUE_W-1:0];
    assign m_saturation = (mx_reg[QH] == '0) ? '0 : q_s_reg[QH];
    assign m_brightness = mx_reg[QH];
    assign m_frame_end  = eof_reg[QH];

endmodule

@@ test/hsv_checker.sv @@
// Scoreboard for the RGB to HSV pixel converter: predicts each pixel and checks every result.
module hsv_checker #(
    parameter int HUE_FRAC_BITS = rgb2hsv_pkg::HUE_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [rgb2hsv_pkg::CH_W-1:0]  s_red,
    input  logic [rgb2hsv_pkg::CH_W-1:0]  s_green,
    input  logic [rgb2hsv_pkg::CH_W-1:0]  s_blue,
    input  logic                          s_end_of_frame,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [rgb2hsv_pkg::HUE_W-1:0] m_hue,
    input  logic [rgb2hsv_pkg::CH_W-1:0]  m_saturation,
    input  logic [rgb2hsv_pkg::CH_W-1:0]  m_brightness,
    input  logic                          m_frame_end,
    output int                            n_pending,
    output int                            n_fail
);
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2hsv_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  bright;
        logic             frame_end;
    } hsv_pixel_t;

    hsv_pixel_t hsv_expected_q[$];
    int         errors   = 0;
    int         n_result = 0;

    assign n_fail = errors;

    task automatic flag_error(input string msg);
        $display("[%0t] checker: result %0d: %s", $realtime, n_result, msg);
        errors++;
    endtask

    function automatic hsv_pixel_t hsv_of(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                          input logic [CH_W-1:0] b, input logic eof);
        int         ri;
        int         gi;
        int         bi;
        int         mx;
        int         mn;
        int         delta;
        longint     num;
        longint     q;
        hsv_pixel_t px;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta = mx - mn;
        q = 0;
        if (delta != 0) begin
            // branch order red, green, blue on ties
            if (mx == ri) begin
                num = HUE_SCALE * (gi - bi);
                if (num < 0) num += HUE_WRAP * delta;
            end else if (mx == gi) begin
                num = HUE_SCALE * (bi - ri) + HUE_OFF_GREEN * delta;
            end else begin
                num = HUE_SCALE * (ri - gi) + HUE_OFF_BLUE * delta;
            end
            q = (num << HUE_FRAC_BITS) / delta;
        end
        px.hue       = q[HUE_W-1:0];
        px.sat       = (mx != 0) ? CH_W'((delta * SAT_SCALE) / mx) : '0;
        px.bright    = CH_W'(mx);
        px.frame_end = eof;
        return px;
    endfunction

    always @(posedge aclk) begin
        hsv_pixel_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (hsv_expected_q.size() == 0) begin
                    flag_error("result with no pixel outstanding");
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (m_hue !== want.hue)
                        flag_error($sformatf("hue %0d, want %0d", m_hue, want.hue));
                    if (m_saturation !== want.sat)
                        flag_error($sformatf("saturation %0d, want %0d",
                                             m_saturation, want.sat));
                    if (m_brightness !== want.bright)
                        flag_error($sformatf("brightness %0d, want %0d",
                                             m_brightness, want.bright));
                    if (m_frame_end !== want.frame_end)
                        flag_error($sformatf("frame_end %0b, want %0b",
                                             m_frame_end, want.frame_end));
                end
                n_result++;
            end
            if (s_valid && s_ready)
                hsv_expected_q = {hsv_expected_q,
                                  hsv_of(s_red, s_green, s_blue, s_end_of_frame)};
        end
        n_pending <= hsv_expected_q.size();
    end

endmodule

@@ test/tb_rgb_to_hsv_pixel_top.sv @@
// Testbench top for the RGB to HSV pixel converter: stimulus, backpressure and verdict.
module tb_rgb_to_hsv_pixel_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2hsv_pkg::*;

    localparam int HUE_FRAC  = HUE_FRAC_DEF;
    // pipe depth of the block (front-end stages plus one per hue quotient bit), plus margin for the drain tail
    localparam int LATENCY   = 12 + HUE_FRAC;
    localparam int TAIL      = 4 * LATENCY;
    localparam int N_RANDOM  = 900;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid;
    logic              s_ready;
    logic [CH_W-1:0]   s_red;
    logic [CH_W-1:0]   s_green;
    logic [CH_W-1:0]   s_blue;
    logic              s_end_of_frame;
    logic              m_valid;
    logic              m_ready;
    logic [HUE_W-1:0]  m_hue;
    logic [CH_W-1:0]   m_saturation;
    logic [CH_W-1:0]   m_brightness;
    logic              m_frame_end;

    int n_pending;
    int n_fail;

    // when set, the sender drives back-to-back transactions
    bit tx_steady = 1'b0;

    always #1 aclk = ~aclk;

    rgb_to_hsv_pixel_top #(
        .HUE_FRAC_BITS (HUE_FRAC)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hue          (m_hue),
        .m_saturation   (m_saturation),
        .m_brightness   (m_brightness),
        .m_frame_end    (m_frame_end)
    );

    hsv_checker #(
        .HUE_FRAC_BITS (HUE_FRAC)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .s_end_of_frame (s_end_of_frame),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hue          (m_hue),
        .m_saturation   (m_saturation),
        .m_brightness   (m_brightness),
        .m_frame_end    (m_frame_end),
        .n_pending      (n_pending),
        .n_fail         (n_fail)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One input transaction. Entered just after a rising edge (or after reset),
    // drives at the falling edge and returns just after the accepting edge.
    // Valid is only lowered when a gap is taken, so it never drops and rises
    // within one time step.
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b, input logic eof);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_red          <= r;
        s_green        <= g;
        s_blue         <= b;
        s_end_of_frame <= eof;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Sender holds off until the pipe has delivered everything outstanding.
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
    endtask

    // Random pixel, weighted toward greys, ties and channel extremes so every
    // hue branch and the special cases keep showing up.
    task automatic random_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
                                output logic [CH_W-1:0] b);
        int kind;
        int hi;
        int lo;
        logic [CH_W-1:0] corner [4];
        corner = '{8'd0, 8'd1, 8'd254, 8'd255};
        kind = $urandom_range(0, 9);
        r = CH_W'($urandom_range(0, 255));
        g = CH_W'($urandom_range(0, 255));
        b = CH_W'($urandom_range(0, 255));
        case (kind)
            6: begin
                g = r;
                b = r;
            end
            7: begin
                // two channels share the maximum
                hi = $urandom_range(1, 255);
                lo = $urandom_range(0, hi);
                case ($urandom_range(0, 2))
                    0: begin r = CH_W'(hi); g = CH_W'(hi); b = CH_W'(lo); end
                    1: begin r = CH_W'(lo); g = CH_W'(hi); b = CH_W'(hi); end
                    default: begin r = CH_W'(hi); g = CH_W'(lo); b = CH_W'(hi); end
                endcase
            end
            8: begin
                r = corner[$urandom_range(0, 3)];
                g = corner[$urandom_range(0, 3)];
                b = corner[$urandom_range(0, 3)];
            end
            9: begin
                r = CH_W'($urandom_range(0, 3));
                g = CH_W'($urandom_range(0, 3));
                b = CH_W'($urandom_range(0, 3));
            end
            default: ;
        endcase
    endtask

    // Receiver: random stalls, mostly short with a few long ones, and
    // stretches with no stall at all. Changes only at the falling edge.
    initial begin
        int stall;
        int span;
        bit rx_steady;
        m_ready   = 1'b0;
        stall     = 0;
        span      = 0;
        rx_steady = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (span == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
                span      = $urandom_range(50, 300);
            end
            span--;
            if (stall == 0 && !rx_steady && $urandom_range(0, 99) < 25) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        s_valid        = 1'b0;
        s_red          = '0;
        s_green        = '0;
        s_blue         = '0;
        s_end_of_frame = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: black, greys, primaries, ties in each branch order,
        // negative red hue that must wrap, and one-LSB pixels.
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0);   // black: saturation 0, hue 0
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);   // white grey
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);   // mid grey
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0);   // pure red
        send_pixel(8'd0,   8'd255, 8'd0,   1'b0);   // pure green
        send_pixel(8'd0,   8'd0,   8'd255, 1'b1);   // pure blue
        send_pixel(8'd255, 8'd0,   8'd1,   1'b0);   // red hue just below zero wraps
        send_pixel(8'd255, 8'd0,   8'd255, 1'b0);   // red/blue tie: red branch, wraps
        send_pixel(8'd255, 8'd255, 8'd0,   1'b0);   // red/green tie: red branch
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0);   // green/blue tie: green branch
        send_pixel(8'd1,   8'd0,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd1,   8'd0,   1'b0);
        send_pixel(8'd0,   8'd0,   8'd1,   1'b1);
        send_pixel(8'd254, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd255, 8'd1,   8'd0,   1'b0);
        send_pixel(8'd1,   8'd2,   8'd255, 1'b0);   // blue hue just below 240
        send_pixel(8'd10,  8'd20,  8'd30,  1'b0);
        send_pixel(8'd200, 8'd100, 8'd50,  1'b1);
        send_pixel(8'd255, 8'd254, 8'd253, 1'b0);   // tiny delta, large max
        send_pixel(8'd170, 8'd85,  8'd255, 1'b0);

        // Random part; sender pacing is rerolled every hundred pixels, and
        // halfway through the sender waits for the pipe to drain empty.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            if (i == N_RANDOM / 2) hold_until_drained();
            random_pixel(r, g, b);
            send_pixel(r, g, b, ($urandom_range(0, 15) == 0));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        // let anything spurious still in the pipe come out and get flagged
        repeat (TAIL) @(posedge aclk);

        if (n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
